// ----- hw/rtl/nahf_pkg.sv -----
// shared types, constants and the small divide function for the hole-fill block
`timescale 1ns / 1ps
package nahf_pkg;

    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 26;
    localparam int RES_W      = 25;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 10;
    localparam int CNT_W      = 3;
    localparam int VALID_BIT  = 24;
    localparam int REGION_BIT = 25;

    localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [SUM_W-1:0] RECIP3    = 10'd683;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic       pixel_valid;
        logic       in_region;
    } nahf_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       valid_out;
        logic       frame_end;
    } nahf_out_t;

    typedef struct packed {
        logic emit;
        logic wr_held;
        logic has_up;
        logic has_down;
        logic has_left;
        logic has_right;
        logic frame_end;
    } nahf_flags_t;

    localparam int FLAGS_W = $bits(nahf_flags_t);

    // floor(sum / cnt) for cnt of one to four
    function automatic logic [CH_W-1:0] nahf_div_count(input logic [SUM_W-1:0] sum,
                                                       input logic [CNT_W-1:0] cnt);
        logic [2*SUM_W-1:0] prod;
        logic [CH_W-1:0]    quo;
        prod = sum * RECIP3;
        unique case (cnt)
            3'd1:    quo = sum[CH_W-1:0];
            3'd2:    quo = sum[CH_W:1];
            3'd3:    quo = prod[CH_W+10:11];
            3'd4:    quo = sum[CH_W+1:2];
            default: quo = '0;
        endcase
        return quo;
    endfunction

endpackage

// ----- hw/rtl/nahf_queue.sv -----
// two-entry fifo between the classifier and the fill engine
`timescale 1ns / 1ps
module nahf_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              push_ready,
    output logic              pop_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;

    assign push_ready = count_reg != (PTR_W+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/nahf_front.sv -----
// input classifier: raster counters, drain tracking and neighbor flags
`timescale 1ns / 1ps
module nahf_front
    import nahf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  nahf_in_t                        s_item,
    input  logic [((($clog2(MAX_WIDTH+1)) > FW_W) ? $clog2(MAX_WIDTH+1) : FW_W)-1:0] eff_w,
    input  logic [FH_W-1:0]                 eff_h,
    input  logic                            q_ready,
    output logic                            q_push,
    output nahf_flags_t                     q_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]    q_col,
    output logic [PIX_W-1:0]                q_pix
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = ($clog2(MAX_WIDTH+1) > FW_W) ? $clog2(MAX_WIDTH+1) : FW_W;

    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             draining_reg;

    logic accept;
    logic is_flush;
    logic in_col_last;
    logic in_row_last;
    logic out_col_last;
    logic out_row_last;

    assign s_ready      = q_ready;
    assign accept       = s_valid && s_ready;
    assign is_flush     = s_item.cmd == CMD_FLUSH;
    assign in_col_last  = (EW'(in_col_reg) + EW'(1)) >= eff_w;
    assign out_col_last = (EW'(out_col_reg) + EW'(1)) >= eff_w;
    assign in_row_last  = (FH_W'(in_row_reg) + FH_W'(1)) >= eff_h;
    assign out_row_last = (FH_W'(out_row_reg) + FH_W'(1)) >= eff_h;

    always_comb begin
        q_flags = '0;
        if (draining_reg) begin
            q_push            = accept && is_flush;
            q_col             = out_col_reg;
            q_pix             = '0;
            q_flags.emit      = 1'b1;
            q_flags.has_up    = out_row_reg != '0;
            q_flags.has_left  = out_col_reg != '0;
            q_flags.has_right = !out_col_last;
            q_flags.frame_end = out_row_last && out_col_last;
        end else begin
            q_push            = accept && !is_flush;
            q_col             = in_col_reg;
            q_pix             = {s_item.in_region, s_item.pixel_valid, s_item.red_in,
                                 s_item.green_in, s_item.blue_in};
            q_flags.emit      = in_row_reg != '0;
            q_flags.wr_held   = 1'b1;
            q_flags.has_down  = 1'b1;
            q_flags.has_up    = in_row_reg > ROW_W'(1);
            q_flags.has_left  = in_col_reg != '0;
            q_flags.has_right = !in_col_last;
            q_flags.frame_end = (FH_W'(in_row_reg) >= eff_h) && in_col_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            draining_reg <= 1'b0;
        end else if (q_push) begin
            if (draining_reg) begin
                if (out_col_last) begin
                    out_col_reg <= '0;
                    if (out_row_last) begin
                        out_row_reg  <= '0;
                        draining_reg <= 1'b0;
                    end else begin
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end else begin
                if (in_col_last) begin
                    in_col_reg <= '0;
                    if (in_row_last) begin
                        in_row_reg   <= '0;
                        draining_reg <= 1'b1;
                        out_row_reg  <= ROW_W'(eff_h - FH_W'(1));
                        out_col_reg  <= '0;
                    end else begin
                        in_row_reg <= in_row_reg + ROW_W'(1);
                    end
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
        end
    end

endmodule

// ----- hw/rtl/nahf_back.sv -----
// fill engine: row memories, neighbor average and output register
`timescale 1ns / 1ps
module nahf_back
    import nahf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  nahf_flags_t                  q_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
    input  logic [PIX_W-1:0]             q_pix,
    output logic                         m_valid,
    input  logic                         m_ready,
    output nahf_out_t                    m_item
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0] held_mem   [MAX_WIDTH];
    logic [RES_W-1:0] filled_mem [MAX_WIDTH];

    logic             s2_valid_reg;
    logic             s2_valid_next;
    nahf_flags_t      s2_flags_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [RES_W-1:0] down_reg;
    logic [PIX_W-1:0] center_reg;
    logic [PIX_W-1:0] right_reg;
    logic [RES_W-1:0] up_mem_reg;
    logic             fwd_hit_reg;
    logic [RES_W-1:0] fwd_pix_reg;
    logic [RES_W-1:0] left_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    nahf_out_t        m_item_reg;

    logic             s2_adv;
    logic             issue;
    logic [COL_W-1:0] col_nx;
    logic [RES_W-1:0] nb      [4];
    logic             nb_use  [4];
    logic [SUM_W-1:0] sum     [3];
    logic [CNT_W-1:0] cnt;
    logic [RES_W-1:0] res;
    logic             fill;

    assign s2_adv  = s2_valid_reg && (!m_valid_reg || m_ready);
    assign issue   = q_valid && (!s2_valid_reg || s2_adv);
    assign q_pop   = issue;
    assign col_nx  = q_col + COL_W'(1);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (issue) begin
            s2_valid_next = q_flags.emit;
        end else if (s2_adv) begin
            s2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s2_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // up, down, left, right
    always_comb begin
        nb[0]     = fwd_hit_reg ? fwd_pix_reg : up_mem_reg;
        nb[1]     = down_reg;
        nb[2]     = left_reg;
        nb[3]     = right_reg[RES_W-1:0];
        nb_use[0] = s2_flags_reg.has_up    && nb[0][VALID_BIT];
        nb_use[1] = s2_flags_reg.has_down  && nb[1][VALID_BIT];
        nb_use[2] = s2_flags_reg.has_left  && nb[2][VALID_BIT];
        nb_use[3] = s2_flags_reg.has_right && nb[3][VALID_BIT];
        cnt = CNT_W'(nb_use[0]) + CNT_W'(nb_use[1]) + CNT_W'(nb_use[2]) + CNT_W'(nb_use[3]);
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int k = 0; k < 4; k++) begin
                if (nb_use[k]) begin
                    sum[ch] = sum[ch] + SUM_W'(nb[k][ch*CH_W +: CH_W]);
                end
            end
        end
        fill = !center_reg[VALID_BIT] && center_reg[REGION_BIT] && (cnt != '0);
        if (fill) begin
            res = {1'b1, nahf_div_count(sum[2], cnt), nahf_div_count(sum[1], cnt),
                   nahf_div_count(sum[0], cnt)};
        end else begin
            res = center_reg[RES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            center_reg <= held_mem[q_col];
            right_reg  <= held_mem[col_nx];
            up_mem_reg <= filled_mem[q_col];
            if (q_flags.wr_held) begin
                held_mem[q_col] <= q_pix;
            end
        end
        if (s2_adv) begin
            filled_mem[s2_col_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            left_reg     <= '0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s2_adv) begin
                left_reg <= res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s2_flags_reg <= q_flags;
            s2_col_reg   <= q_col;
            down_reg     <= q_pix[RES_W-1:0];
            fwd_hit_reg  <= s2_adv && (s2_col_reg == q_col);
            fwd_pix_reg  <= res;
        end
        if (s2_adv) begin
            m_item_reg.blue_out  <= res[CH_W-1:0];
            m_item_reg.green_out <= res[2*CH_W-1:CH_W];
            m_item_reg.red_out   <= res[3*CH_W-1:2*CH_W];
            m_item_reg.valid_out <= res[VALID_BIT];
            m_item_reg.frame_end <= s2_flags_reg.frame_end;
        end
    end

endmodule

// ----- hw/rtl/neighbor_average_hole_fill.sv -----
// top level: config registers, classifier, queue and fill engine
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid / s_ready  s_item (nahf_in_t)
//   m_*          out  m_valid / m_ready  m_item (nahf_out_t)
//   cfg_*        in   cfg_wr_en          cfg_index, cfg_wdata
//
// one item per cycle sustained while m_ready is high; the fill engine registers
// its reads of both row memories, averages from those registers and registers
// the result for output, one row behind the input
// aresetn clears counters, drain state and valids; row memories are not cleared
// a stalled m_ready backs up through the two-entry queue to s_ready
`timescale 1ns / 1ps
module neighbor_average_hole_fill
    import nahf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  nahf_in_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output nahf_out_t             m_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW     = ($clog2(MAX_WIDTH+1) > FW_W) ? $clog2(MAX_WIDTH+1) : FW_W;
    localparam int QDAT_W = FLAGS_W + COL_W + PIX_W;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [EW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;

    logic              q_push;
    logic              q_ready;
    logic              q_valid;
    logic              q_pop;
    nahf_flags_t       f_flags;
    logic [COL_W-1:0]  f_col;
    logic [PIX_W-1:0]  f_pix;
    logic [QDAT_W-1:0] q_out;
    nahf_flags_t       b_flags;
    logic [COL_W-1:0]  b_col;
    logic [PIX_W-1:0]  b_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_W'(1024);
            frame_height_reg <= FH_W'(768);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = EW'(1);
        end else if (EW'(frame_width_reg) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            eff_h = FH_W'(1);
        end else if (frame_height_reg > MAX_HEIGHT) begin
            eff_h = MAX_HEIGHT;
        end else begin
            eff_h = frame_height_reg;
        end
    end

    nahf_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_flags (f_flags),
        .q_col   (f_col),
        .q_pix   (f_pix)
    );

    nahf_queue #(
        .DATA_W(QDAT_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  ({f_flags, f_col, f_pix}),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_out)
    );

    assign b_flags = q_out[QDAT_W-1 -: FLAGS_W];
    assign b_col   = q_out[PIX_W +: COL_W];
    assign b_pix   = q_out[PIX_W-1:0];

    nahf_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_flags (b_flags),
        .q_col   (b_col),
        .q_pix   (b_pix),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef ASSERT_OFF
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_ready)
        else $error("classifier pushed into a full queue");

    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> q_valid)
        else $error("queue empty right after a push");

    a_end_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && b_flags.emit && b_flags.frame_end) |-> !b_flags.has_right)
        else $error("frame end flagged on a column with a right neighbor");
`endif

endmodule
